FILE: design/dda_line_rasterizer_macros.svh
// assertion macros for the dda line rasterizer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dda_pkg.sv
// shared types and constants for the dda line rasterizer
// no dependencies; imported by every module of the block
package dda_pkg;

  // coordinate width is fixed by the payload fields
  localparam int unsigned COORD_BITS    = 12;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // item function codes
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } dda_func_e;

  // input transaction payload
  typedef struct packed {
    dda_func_e             func;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } dda_in_t;

  // output transaction payload
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;
  } dda_out_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } dda_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic start;       // load endpoints, seed accumulators and divider
    logic div_step;    // one restoring division step on both axes
    logic div_finish;  // write signed increments
    logic advance;     // emit pixel and step accumulators
  } dda_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic line_active;
  } dda_status_t;

endpackage

FILE: design/dda_ctrl.sv
// controller for the dda line rasterizer: handshakes, divider sequencing
// depends on dda_pkg
module dda_ctrl import dda_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  dda_func_e   in_func_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  dda_status_t status_i,
  output dda_cmd_t    cmd_o
);

  localparam int unsigned CntW = $clog2(FRAC_BITS + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(FRAC_BITS);

  dda_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            accept;

  // state, counter and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;

    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = (state_q != ST_IDLE) || !out_free;
    accept     = in_valid_i && !in_stall_o;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_func_i == FUNC_START)) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = ST_DIVIDE;
        end
        if (accept && (in_func_i == FUNC_STEP) && status_i.line_active) begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.div_finish = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // output register valid
    if (cmd_o.advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/dda_dpath.sv
// datapath for the dda line rasterizer: deltas, dividers, accumulators
// depends on dda_pkg
module dda_dpath import dda_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dda_in_t     in_i,
  input  dda_cmd_t    cmd_i,
  output dda_status_t status_o,
  output dda_out_t    out_o
);

  localparam int unsigned AccW  = COORD_BITS + FRAC_BITS;
  localparam int unsigned IncW  = AccW + 1;
  localparam int unsigned NumW  = AccW + 1;
  localparam int unsigned QuoW  = FRAC_BITS + 1;
  localparam int unsigned LeftW = COORD_BITS + 1;

  // line set-up values
  logic                  xneg, yneg;
  logic [COORD_BITS-1:0] adx, ady, steps;
  logic [NumW-1:0]       num_x, num_y;

  // divider and line state
  logic [COORD_BITS-1:0] steps_q;
  logic                  xneg_q, yneg_q;
  logic [COORD_BITS-1:0] xrem_q, yrem_q;
  logic [QuoW-1:0]       xlow_q, ylow_q;
  logic [QuoW-1:0]       xquo_q, yquo_q;
  logic [AccW-1:0]       xacc_q, yacc_q;
  logic [IncW-1:0]       xinc_q, yinc_q;
  logic [LeftW-1:0]      left_q;
  dda_out_t              out_q;

  // division step results
  logic [COORD_BITS:0]   xtrial, ytrial, div_d;
  logic [COORD_BITS-1:0] xdiff, ydiff;
  logic                  xge, yge;
  logic [COORD_BITS-1:0] xrem_next, yrem_next;
  logic [IncW-1:0]       xq_ext, yq_ext, xinc_d, yinc_d;

  // absolute deltas, step count and rounded numerators
  always_comb begin
    xneg  = in_i.x_end < in_i.x_start;
    yneg  = in_i.y_end < in_i.y_start;
    adx   = xneg ? (in_i.x_start - in_i.x_end) : (in_i.x_end - in_i.x_start);
    ady   = yneg ? (in_i.y_start - in_i.y_end) : (in_i.y_end - in_i.y_start);
    steps = (adx >= ady) ? adx : ady;
    num_x = {1'b0, adx, {FRAC_BITS{1'b0}}} + NumW'(steps >> 1);
    num_y = {1'b0, ady, {FRAC_BITS{1'b0}}} + NumW'(steps >> 1);
  end

  // restoring division, one quotient bit per cycle on each axis
  // the remainder stays below the divisor, so the low bits of the difference suffice
  always_comb begin
    div_d     = {1'b0, steps_q};
    xtrial    = {xrem_q, xlow_q[QuoW-1]};
    ytrial    = {yrem_q, ylow_q[QuoW-1]};
    xge       = xtrial >= div_d;
    yge       = ytrial >= div_d;
    xdiff     = xtrial[COORD_BITS-1:0] - steps_q;
    ydiff     = ytrial[COORD_BITS-1:0] - steps_q;
    xrem_next = xge ? xdiff : xtrial[COORD_BITS-1:0];
    yrem_next = yge ? ydiff : ytrial[COORD_BITS-1:0];
  end

  // signed increments, zero for a zero-length line
  always_comb begin
    xq_ext = IncW'(xquo_q);
    yq_ext = IncW'(yquo_q);
    if (steps_q == '0) begin
      xinc_d = '0;
      yinc_d = '0;
    end else begin
      xinc_d = xneg_q ? (IncW'(0) - xq_ext) : xq_ext;
      yinc_d = yneg_q ? (IncW'(0) - yq_ext) : yq_ext;
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xacc_q <= '0;
      yacc_q <= '0;
      xinc_q <= '0;
      yinc_q <= '0;
      left_q <= '0;
    end else begin
      if (cmd_i.start) begin
        xacc_q <= {in_i.x_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
        yacc_q <= {in_i.y_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
        xinc_q <= '0;
        yinc_q <= '0;
        left_q <= {1'b0, steps} + LeftW'(1);
      end else if (cmd_i.advance) begin
        xacc_q <= xacc_q + xinc_q[AccW-1:0];
        yacc_q <= yacc_q + yinc_q[AccW-1:0];
        left_q <= left_q - LeftW'(1);
      end else if (cmd_i.div_finish) begin
        xinc_q <= xinc_d;
        yinc_q <= yinc_d;
      end
    end
  end

  // divider working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      steps_q <= steps;
      xneg_q  <= xneg;
      yneg_q  <= yneg;
      xrem_q  <= num_x[NumW-1:QuoW];
      yrem_q  <= num_y[NumW-1:QuoW];
      xlow_q  <= num_x[QuoW-1:0];
      ylow_q  <= num_y[QuoW-1:0];
      xquo_q  <= '0;
      yquo_q  <= '0;
    end else if (cmd_i.div_step) begin
      xrem_q <= xrem_next;
      yrem_q <= yrem_next;
      xlow_q <= {xlow_q[QuoW-2:0], 1'b0};
      ylow_q <= {ylow_q[QuoW-2:0], 1'b0};
      xquo_q <= {xquo_q[QuoW-2:0], xge};
      yquo_q <= {yquo_q[QuoW-2:0], yge};
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      out_q.pixel_x <= xacc_q[AccW-1:FRAC_BITS];
      out_q.pixel_y <= yacc_q[AccW-1:FRAC_BITS];
      out_q.last    <= left_q == LeftW'(1);
    end
  end

  assign status_o.line_active = left_q != '0;
  assign out_o                = out_q;

endmodule

FILE: design/dda_line_rasterizer.sv
// DDA line rasterizer top level: joins the controller and the datapath.
// A start transaction (func = start) loads two endpoints and gives no result;
// each step transaction then gives one rounded pixel, both endpoints included,
// with last set on the end pixel, and a step with no line active gives nothing.
// A step is taken every cycle while the output register is free or being
// drained. After a start the input stalls while the x and y increments come
// from a restoring divider that makes one quotient bit per cycle, and then
// while the signed increments are written.
// A start replaces any line still in progress. Depends on dda_pkg.
module dda_line_rasterizer import dda_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dda_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dda_out_t out_o
);

  dda_cmd_t    cmd;
  dda_status_t status;

  // handshake control and divider sequencing
  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and line state
  dda_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

endmodule

FILE: design/dda_checker.sv
// port-level checks for the dda line rasterizer, bound to the top level
// depends on dda_pkg and dda_line_rasterizer_macros.svh
`include "dda_line_rasterizer_macros.svh"

module dda_checker import dda_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input dda_in_t  in_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input dda_out_t out_o
);

  // a stalled result stays offered and unchanged
  `DDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_o), "stalled output transaction changed")

  // a blocked output register holds off new input
  `DDA_ASSERT_NOW(a_backpressure, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o, "input taken while output blocked")

  // the divider keeps the input stalled after a start
  `DDA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_i.func == FUNC_START), in_stall_o ##1 in_stall_o, "input taken while divider busy")

endmodule

bind dda_line_rasterizer dda_checker u_checker (.*);

FILE: dv/tb.sv
// testbench for dda_line_rasterizer: directed lines, random lines and a back-pressure run
// predicts every pixel from its own fixed-point line stepper; depends on dda_pkg
`timescale 1ns / 100ps

module tb;
  import dda_pkg::*;

  // fixed-point widths of the line stepper at the default fraction size
  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int ACC_W  = COORD_BITS + FRAC;
  localparam int INC_W  = ACC_W + 1;
  localparam int LEFT_W = COORD_BITS + 1;
  localparam logic [ACC_W-1:0] HALF_UNIT = ACC_W'(1) << (FRAC - 1);
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  // a start keeps the divider busy with no pixel to wait for
  localparam int DRAIN_CYCLES   = FRAC + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  dda_in_t  in_i;
  logic     out_valid_o;
  logic     out_stall_i;
  dda_out_t out_o;

  // predicted line state
  logic [ACC_W-1:0]  line_x_acc;
  logic [ACC_W-1:0]  line_y_acc;
  logic [INC_W-1:0]  line_x_inc;
  logic [INC_W-1:0]  line_y_inc;
  logic [LEFT_W-1:0] pixels_left;
  dda_out_t          pixel_queue[$];
  dda_out_t          oldest_pixel;

  int mismatch_count     = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_cycles        = 0;
  int idle_cycles        = 0;

  dda_line_rasterizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // rounded fixed-point slope, signed at increment width
  function automatic logic [INC_W-1:0] slope_increment(input logic [COORD_BITS-1:0] mag,
                                                       input logic neg,
                                                       input logic [COORD_BITS-1:0] span);
    longint unsigned quo;
    logic [INC_W-1:0] q;
    if (span == '0) return '0;
    quo = ((longint'(mag) << FRAC) + longint'(span >> 1)) / longint'(span);
    q = quo[INC_W-1:0];
    return neg ? -q : q;
  endfunction

  // update predicted state for one accepted transaction, queue any pixel it gives
  function automatic void rasterize_item(input dda_in_t item);
    logic [COORD_BITS-1:0] adx, ady, span;
    logic xneg, yneg;
    dda_out_t px;
    if (item.func == FUNC_START) begin
      xneg = item.x_end < item.x_start;
      yneg = item.y_end < item.y_start;
      adx  = xneg ? item.x_start - item.x_end : item.x_end - item.x_start;
      ady  = yneg ? item.y_start - item.y_end : item.y_end - item.y_start;
      span = (adx >= ady) ? adx : ady;
      line_x_inc  = slope_increment(adx, xneg, span);
      line_y_inc  = slope_increment(ady, yneg, span);
      line_x_acc  = (ACC_W'(item.x_start) << FRAC) + HALF_UNIT;
      line_y_acc  = (ACC_W'(item.y_start) << FRAC) + HALF_UNIT;
      pixels_left = LEFT_W'(span) + 1'b1;
    end else if (pixels_left != '0) begin
      px.pixel_x = line_x_acc[ACC_W-1:FRAC];
      px.pixel_y = line_y_acc[ACC_W-1:FRAC];
      px.last    = (pixels_left == LEFT_W'(1));
      pixel_queue.push_back(px);
      line_x_acc  = line_x_acc + line_x_inc[ACC_W-1:0];
      line_y_acc  = line_y_acc + line_y_inc[ACC_W-1:0];
      pixels_left = pixels_left - 1'b1;
    end
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // coordinate at or near either end of the range
  function automatic int extreme_coord();
    case ($urandom_range(3))
      0: return 0;
      1: return COORD_MAX;
      2: return $urandom_range(7);
      default: return COORD_MAX - int'($urandom_range(7));
    endcase
  endfunction

  function automatic dda_in_t random_item(input dda_func_e func);
    dda_in_t item;
    item.func    = func;
    item.x_start = COORD_BITS'($urandom);
    item.y_start = COORD_BITS'($urandom);
    item.x_end   = COORD_BITS'($urandom);
    item.y_end   = COORD_BITS'($urandom);
    return item;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: mismatch, %s", $time, msg);
  endtask

  // send one transaction after random idle cycles, predict once accepted
  task automatic send_item(input dda_in_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    rasterize_item(item);
  endtask

  task automatic start_line(input int x0, input int y0, input int x1, input int y1);
    dda_in_t item;
    item.func    = FUNC_START;
    item.x_start = COORD_BITS'(x0);
    item.y_start = COORD_BITS'(y0);
    item.x_end   = COORD_BITS'(x1);
    item.y_end   = COORD_BITS'(y1);
    send_item(item);
  endtask

  task automatic step_pixels(input int n);
    repeat (n) send_item(random_item(FUNC_STEP));
  endtask

  // stop sending and wait for every predicted pixel, then for the divider
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // extremes, rounding on halves, zero length, replaced lines, step with no line
  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    step_pixels(1);
    start_line(0, 0, 0, 0);
    step_pixels(2);
    start_line(0, 0, 2, 1);
    step_pixels(3);
    start_line(2, 1, 0, 0);
    step_pixels(3);
    start_line(COORD_MAX, COORD_MAX, 0, 0);
    step_pixels(2);
    start_line(0, COORD_MAX, COORD_MAX, 0);
    step_pixels(2);
    start_line(COORD_MAX, 0, COORD_MAX, COORD_MAX);
    step_pixels(1);
    start_line(100, 200, 99, 203);
    step_pixels(5);
    wait_drain();
  endtask

  // random lines, mostly short and run to the end, some long and cut off
  task automatic test_random_lines(input int idle_pct, input int stall_pct, input int budget);
    int sent, kind, pixels, n, dx, dy;
    int x0, y0, x1, y1;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 8) begin
        send_item(random_item(dda_func_e'($urandom_range(1))));
        sent++;
      end else begin
        kind = $urandom_range(99);
        x0 = $urandom_range(COORD_MAX);
        y0 = $urandom_range(COORD_MAX);
        if (kind < 65) begin
          x1 = clamp_coord(x0 + int'($urandom_range(40)) - 20);
          y1 = clamp_coord(y0 + int'($urandom_range(40)) - 20);
        end else if (kind < 80) begin
          x0 = extreme_coord();
          y0 = extreme_coord();
          x1 = extreme_coord();
          y1 = extreme_coord();
        end else begin
          x1 = $urandom_range(COORD_MAX);
          y1 = $urandom_range(COORD_MAX);
        end
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        pixels = ((dx > dy) ? dx : dy) + 1;
        if (pixels > 48) n = $urandom_range(48, 1);
        else if ($urandom_range(99) < 80) n = pixels + int'($urandom_range(2));
        else n = $urandom_range(pixels);
        start_line(x0, y0, x1, y1);
        step_pixels(n);
        sent += 1 + n;
      end
    end
    wait_drain();
  endtask

  // receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_cycles        = 200;
    start_line(0, 0, 59, 20);
    step_pixels(60);
    wait_drain();
  endtask

  // receiver stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // compare each accepted pixel with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pixel_queue.size() == 0) begin
        note_mismatch($sformatf("pixel (%0d, %0d) last %0b with none predicted",
                                out_o.pixel_x, out_o.pixel_y, out_o.last));
      end else begin
        oldest_pixel = pixel_queue.pop_front();
        if (out_o.pixel_x !== oldest_pixel.pixel_x)
          note_mismatch($sformatf("pixel_x expected %0d got %0d",
                                  oldest_pixel.pixel_x, out_o.pixel_x));
        if (out_o.pixel_y !== oldest_pixel.pixel_y)
          note_mismatch($sformatf("pixel_y expected %0d got %0d",
                                  oldest_pixel.pixel_y, out_o.pixel_y));
        if (out_o.last !== oldest_pixel.last)
          note_mismatch($sformatf("last expected %0b got %0b",
                                  oldest_pixel.last, out_o.last));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // reset, then the tests in turn
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    out_stall_i = 1'b0;
    pixels_left = '0;
    line_x_acc  = '0;
    line_y_acc  = '0;
    line_x_inc  = '0;
    line_y_inc  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_lines(0, 0, 150);
    test_random_lines(75, 0, 150);
    test_random_lines(0, 75, 150);
    test_random_lines(25, 25, 150);
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/dda_pkg.sv
design/dda_ctrl.sv
design/dda_dpath.sv
design/dda_line_rasterizer.sv
design/dda_checker.sv
dv/tb.sv
